### rtl/swm_pkg.sv
// Shared types for the sliding-window median filter.
// Used by swm_cell and sliding_window_median_top; no dependencies.
package swm_pkg;

    localparam int SAMPLE_W = 32;
    localparam int MEDIAN_W = 33;
    localparam int CFG_W    = 6;

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic signed [MEDIAN_W-1:0] median_t;

    // Broadcast control from the top level to every cell.
    typedef struct packed {
        logic                 en;    // an input transfer updates the chain
        logic                 drop;  // window is full: the oldest sample leaves
        logic [SAMPLE_W-1:0]  smp;   // the incoming sample
    } swm_ctl_t;

    // Flags a cell hands to its right-hand neighbor.
    typedef struct packed {
        logic rem;   // a sample was removed at or left of this cell
        logic gt;    // this compacted slot holds a value above the new sample
    } swm_flags_t;

endpackage

### rtl/swm_cell.sv
// One slot of the sorted window: holds a sample value and its age.
// Depends on swm_pkg; instantiated in a row by sliding_window_median_top.
module swm_cell
    import swm_pkg::*;
#(
    parameter int AW = 5
) (
    input  logic             clk,
    input  swm_ctl_t         ctl,
    input  logic [AW-1:0]    drop_age,
    input  logic             holds_old,   // slot holds a sample before this transfer
    input  logic             live,        // slot is inside the compacted window
    // From the left neighbor.
    input  swm_flags_t       l_flags,
    input  sample_t          l_cval,
    input  logic [AW-1:0]    l_cage,
    // From the right neighbor.
    input  sample_t          r_val,
    input  logic [AW-1:0]    r_age,
    input  logic             r_cmp,
    // To the right neighbor.
    output swm_flags_t       flags,
    output sample_t          cval,
    output logic [AW-1:0]    cage,
    // To the left neighbor and the median select.
    output sample_t          val,
    output logic [AW-1:0]    age,
    output logic             cmp
);

    sample_t         val_reg, val_next;
    logic [AW-1:0]   age_reg, age_next;
    sample_t         smp;
    logic            rm;

    assign smp = ctl.smp;

    // Compare against the new sample and detect the outgoing oldest sample.
    assign cmp = (val_reg > smp);
    assign rm  = ctl.drop && holds_old && (age_reg == drop_age);

    // Compacted view after the removal: slots right of the hole shift left.
    assign flags.rem = l_flags.rem | rm;
    assign cval      = flags.rem ? r_val : val_reg;
    assign cage      = flags.rem ? r_age : age_reg;
    assign flags.gt  = live ? (flags.rem ? r_cmp : cmp) : 1'b1;

    // Insertion: keep the compacted value, take the new sample, or shift right.
    always_comb
    begin
        if (!flags.gt)
        begin
            val_next = cval;
            age_next = cage + AW'(1);
        end
        else if (!l_flags.gt)
        begin
            val_next = smp;
            age_next = '0;
        end
        else
        begin
            val_next = l_cval;
            age_next = l_cage + AW'(1);
        end
    end

    // Slot contents are payload and need no reset.
    always_ff @(posedge clk)
    begin
        if (ctl.en)
        begin
            val_reg <= val_next;
            age_reg <= age_next;
        end
    end

    assign val = val_reg;
    assign age = age_reg;

endmodule

### rtl/sliding_window_median_top.sv
// Top level of the sliding-window median filter: cell row, fill control, output stage.
// Depends on swm_pkg and swm_cell.

// Running median over the last window_length signed 32-bit samples (1 to WINDOW_MAX;
// a write of zero means 1, larger values saturate to WINDOW_MAX). The block takes one
// sample per clock unless a pending result waits on the output: a row of WINDOW_MAX
// cells keeps the window sorted, and each transfer inserts the new sample and, once
// the window is full, removes the oldest one. Once the window is full every sample
// gives one result, twice the median (the sum of the two middle values for an even
// window), kept pending until the output register is free; the output register lets
// the next sample enter while a result still waits; fill-phase samples give no result.
// Any write to window_length empties the window; write it only while the block is idle.
module sliding_window_median_top
    import swm_pkg::*;
#(
    parameter int WINDOW_MAX = 32
) (
    input  logic               clk,
    input  logic               rst_n,
    // Configuration: window_length.
    input  logic               cfg_wr_en,
    input  logic [CFG_W-1:0]   cfg_wr_data,
    // Input stream.
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    input  logic [31:0]        s_axis_tdata,   // [31:0] sample
    // Output stream.
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    output logic [39:0]        m_axis_tdata    // [32:0] median_doubled, [39:33] zero
);

    localparam int AW        = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam int LW        = $clog2(WINDOW_MAX + 1);
    localparam int RESET_LEN = (WINDOW_MAX < 3) ? WINDOW_MAX : 3;

    logic [LW-1:0]   len_reg, len_next;
    logic [LW-1:0]   fill_reg, fill_next;
    logic            pend_reg, pend_next;
    logic            out_valid_reg, out_valid_next;
    median_t         out_data_reg, out_data_next;

    logic [LW-1:0]   eff_len;
    logic            full;
    logic            accept;
    logic            produce;
    logic            load;
    logic [LW-1:0]   old_cnt;
    logic [LW-1:0]   live_cnt;
    logic [AW-1:0]   drop_age;
    logic [LW-1:0]   hi_pos;
    logic [LW-1:0]   lo_pos;
    sample_t         mid_lo;
    sample_t         mid_hi;
    swm_ctl_t        ctl;

    swm_flags_t      flags [WINDOW_MAX+1];
    sample_t         cval  [WINDOW_MAX+1];
    logic [AW-1:0]   cage  [WINDOW_MAX+1];
    sample_t         val   [WINDOW_MAX+1];
    logic [AW-1:0]   age   [WINDOW_MAX+1];
    logic            cmp   [WINDOW_MAX+1];

    // Clamp the requested window length into 1..WINDOW_MAX.
    always_comb
    begin
        if (cfg_wr_data == '0)
            eff_len = LW'(1);
        else if (32'(cfg_wr_data) > 32'(WINDOW_MAX))
            eff_len = LW'(WINDOW_MAX);
        else
            eff_len = LW'(cfg_wr_data);
    end

    // Window occupancy and handshake.
    assign full          = (fill_reg == len_reg);
    assign load          = pend_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !pend_reg || load;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign produce       = full || ((fill_reg + LW'(1)) == len_reg);
    assign old_cnt       = full ? len_reg : fill_reg;
    assign live_cnt      = full ? (len_reg - LW'(1)) : fill_reg;
    assign drop_age      = AW'(len_reg - LW'(1));

    assign ctl.en   = accept;
    assign ctl.drop = full;
    assign ctl.smp  = s_axis_tdata;

    // Chain boundaries: nothing removed or larger left of the first cell.
    assign flags[0] = '{rem: 1'b0, gt: 1'b0};
    assign cval[0]  = '0;
    assign cage[0]  = '0;
    assign val[WINDOW_MAX] = '0;
    assign age[WINDOW_MAX] = '0;
    assign cmp[WINDOW_MAX] = 1'b0;

    // Row of sorted cells.
    for (genvar i = 0; i < WINDOW_MAX; i++)
    begin : g_cell
        logic holds_old;
        logic live;

        assign holds_old = (LW'(i) < old_cnt);
        assign live      = (LW'(i) < live_cnt);

        swm_cell #(
            .AW(AW)
        ) u_cell (
            .clk       (clk),
            .ctl       (ctl),
            .drop_age  (drop_age),
            .holds_old (holds_old),
            .live      (live),
            .l_flags   (flags[i]),
            .l_cval    (cval[i]),
            .l_cage    (cage[i]),
            .r_val     (val[i+1]),
            .r_age     (age[i+1]),
            .r_cmp     (cmp[i+1]),
            .flags     (flags[i+1]),
            .cval      (cval[i+1]),
            .cage      (cage[i+1]),
            .val       (val[i]),
            .age       (age[i]),
            .cmp       (cmp[i])
        );
    end

    // Middle slots of the sorted window for the current length.
    assign hi_pos = len_reg >> 1;
    assign lo_pos = len_reg[0] ? hi_pos : (hi_pos - LW'(1));
    assign mid_hi = val[hi_pos];
    assign mid_lo = val[lo_pos];

    // Next-state logic for control and the output register.
    always_comb
    begin
        len_next       = len_reg;
        fill_next      = fill_reg;
        pend_next      = pend_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;

        if (m_axis_tready)
            out_valid_next = 1'b0;
        if (load)
        begin
            out_valid_next = 1'b1;
            out_data_next  = {mid_lo[SAMPLE_W-1], mid_lo} + {mid_hi[SAMPLE_W-1], mid_hi};
            pend_next      = 1'b0;
        end

        if (accept)
        begin
            if (!full)
                fill_next = fill_reg + LW'(1);
            if (produce)
                pend_next = 1'b1;
        end

        if (cfg_wr_en)
        begin
            len_next  = eff_len;
            fill_next = '0;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg       <= LW'(RESET_LEN);
            fill_reg      <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            len_reg       <= len_next;
            fill_reg      <= fill_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Output payload register.
    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {7'b0, out_data_reg};

endmodule
